// ===== hdl/prime_factorizer_core_assert.svh =====
// Assertion macros for the prime factoriser core and its checker.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef PRIME_FACTORIZER_CORE_ASSERT_SVH
`define PRIME_FACTORIZER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PFC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prime factoriser: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prime factoriser: next-cycle check failed");

`endif

// ===== hdl/pf_pkg.sv =====
// ----------------------------------------------------------------------------
// pf_pkg
// Shared widths for the prime factoriser core and its checker.
// ----------------------------------------------------------------------------
package pf_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;

endpackage

// ===== hdl/prime_factorizer_core.sv =====
// ----------------------------------------------------------------------------
// prime_factorizer_core
// Trial-division prime factoriser built around one shared bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_value and raise start; the item is taken at the
//   rising edge where start is high and busy is low. busy stays high for the
//   whole run of a value of two or more.
//   Result channel: each prime factor appears on out_factor for exactly one
//   cycle with out_valid high, in ascending order, repeats included. The
//   final factor carries out_is_last. Values zero and one give one result
//   with out_factor zero, out_is_last and out_empty_res set, and the block
//   stays ready.
//   Steps: each trial step is one restoring division of the cofactor by the
//   trial divisor in ST_DIVIDE, followed by a decision in ST_DECIDE. A prime
//   near 2^31 needs about 46 000 steps. The divider is the one shared unit;
//   a new value is not taken until the run is over and busy falls.
//   The receiver cannot stall: results are strobed and never held. A new item
//   may be taken in the same cycle as the last result of the previous run.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   any run in progress; no result is strobed out of reset.
// ----------------------------------------------------------------------------
module prime_factorizer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pf_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  output logic [pf_pkg::VALUE_WIDTH-1:0] out_factor,
  output logic                          out_is_last,
  output logic                          out_empty_res
);
  import pf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DECIDE
  } state_t;

  localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(VALUE_WIDTH - 1);
  localparam value_t               TWO      = VALUE_WIDTH'(2);

  state_t               state_r;
  value_t               rem_r;     // cofactor still to be factored
  value_t               div_r;     // current trial divisor
  value_t               part_r;    // divider partial remainder
  value_t               quo_r;     // dividend shifting out, quotient shifting in
  logic [CNT_WIDTH-1:0] cnt_r;
  logic                 out_valid_r;
  value_t               out_factor_r;
  logic                 out_is_last_r;
  logic                 out_empty_r;

  // Divider step: bring down the next dividend bit and try the subtraction.
  logic [VALUE_WIDTH:0] shifted;
  logic [VALUE_WIDTH:0] trial;
  logic                 fits;
  value_t               part_nxt;
  value_t               quo_nxt;

  always_comb begin
    shifted  = {part_r, quo_r[VALUE_WIDTH-1]};
    trial    = shifted - {1'b0, div_r};
    fits     = (shifted >= {1'b0, div_r});
    part_nxt = fits ? trial[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
    quo_nxt  = {quo_r[VALUE_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
      div_r       <= '0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            if (in_value < TWO) begin
              // No prime factors: flag the run as empty and stay ready.
              out_valid_r   <= 1'b1;
              out_factor_r  <= '0;
              out_is_last_r <= 1'b1;
              out_empty_r   <= 1'b1;
              rem_r         <= in_value;
              div_r         <= TWO;
            end else begin
              rem_r   <= in_value;
              div_r   <= TWO;
              part_r  <= '0;
              quo_r   <= in_value;
              cnt_r   <= '0;
              state_r <= ST_DIVIDE;
            end
          end
        end
        ST_DIVIDE: begin
          part_r <= part_nxt;
          quo_r  <= quo_nxt;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          // quo_r holds rem / div, part_r holds rem % div.
          priority if (div_r > quo_r) begin
            // Divisor squared exceeds the cofactor: the cofactor is prime.
            out_valid_r   <= 1'b1;
            out_factor_r  <= rem_r;
            out_is_last_r <= 1'b1;
            out_empty_r   <= 1'b0;
            state_r       <= ST_IDLE;
          end else if (part_r == '0) begin
            // Divides evenly: emit the divisor and carry on with the quotient.
            out_valid_r   <= 1'b1;
            out_factor_r  <= div_r;
            out_is_last_r <= 1'b0;
            out_empty_r   <= 1'b0;
            rem_r         <= quo_r;
            part_r        <= '0;
            cnt_r         <= '0;
            state_r       <= ST_DIVIDE;
          end else begin
            // Advance the divisor and divide the same cofactor again.
            div_r   <= div_r + 1'b1;
            part_r  <= '0;
            quo_r   <= rem_r;
            cnt_r   <= '0;
            state_r <= ST_DIVIDE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_factor    = out_factor_r;
  assign out_is_last   = out_is_last_r;
  assign out_empty_res = out_empty_r;

endmodule

// ===== hdl/pf_checker.sv =====
// ----------------------------------------------------------------------------
// pf_checker
// Port-level checks on the prime factoriser core, bound to its top level.
// ----------------------------------------------------------------------------
`include "prime_factorizer_core_assert.svh"

module pf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [pf_pkg::VALUE_WIDTH-1:0] in_value,
  input logic                          out_valid,
  input logic [pf_pkg::VALUE_WIDTH-1:0] out_factor,
  input logic                          out_is_last,
  input logic                          out_empty_res
);
  import pf_pkg::*;

  logic take;
  logic trivial;
  logic real_factor;

  assign take        = start && !busy;
  assign trivial     = (in_value[VALUE_WIDTH-1:1] == '0);
  assign real_factor = (out_factor[VALUE_WIDTH-1:1] != '0);

  `PFC_ASSERT_IMPLY(a_empty_shape, out_valid && out_empty_res, out_is_last && out_factor == '0)
  `PFC_ASSERT_IMPLY(a_factor_min, out_valid && !out_empty_res, real_factor)
  `PFC_ASSERT_IMPLY(a_mid_run_busy, out_valid && !out_is_last, busy)
  `PFC_ASSERT_NEXT(a_run_starts, take && !trivial, busy && !out_valid)
  `PFC_ASSERT_NEXT(a_trivial_result, take && trivial, out_valid && out_empty_res && !busy)

endmodule

bind prime_factorizer_core pf_checker u_pf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_value      (in_value),
  .out_valid     (out_valid),
  .out_factor    (out_factor),
  .out_is_last   (out_is_last),
  .out_empty_res (out_empty_res)
);
